// File: hdl/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// no dependencies; used by the interfaces and every module under hdl

package fbpa_pkg;

    // pool size and derived widths
    localparam int BLOCKS = 256;
    localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W  = $clog2(BLOCKS + 1);

    // fixed field widths of the words
    localparam int BLK_W  = 8;
    localparam int FCNT_W = 9;

    localparam logic [CNT_W-1:0] BLOCKS_C = CNT_W'(BLOCKS);

    // requested operation
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // classified command held in the queue
    typedef struct packed {
        t_op              op;
        logic [BLK_W-1:0] blk;
        logic             blk_ok;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic nonempty;
        logic multi;
    } t_q_stat;

endpackage

// File: hdl/fbpa_if.sv
// fbpa_req_if / fbpa_rsp_if: valid-ready channels for requests and results
// depends on fbpa_pkg for field widths

interface fbpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [fbpa_pkg::BLK_W-1:0]   block_in;

    modport source (output valid, func, block_in, input ready);
    modport sink   (input valid, func, block_in, output ready);
endinterface

interface fbpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [fbpa_pkg::BLK_W-1:0]   block_out;
    logic [fbpa_pkg::FCNT_W-1:0]  free_count;
    logic                         error;

    modport source (output valid, granted, block_out, free_count, error, input ready);
    modport sink   (input valid, granted, block_out, free_count, error, output ready);
endinterface

// File: hdl/fbpa_front.sv
// fbpa_front: accepts request words, classifies them and holds them in a
// two-entry queue; depends on fbpa_pkg and fbpa_req_if

module fbpa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fbpa_req_if.sink             i_req,
    input  logic                 i_pop,
    output fbpa_pkg::t_cmd       o_cmd,
    output fbpa_pkg::t_q_stat    o_stat
);

    fbpa_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    fbpa_pkg::t_cmd cmd_in;

    // classify the incoming word
    always_comb begin
        cmd_in.blk    = i_req.block_in;
        cmd_in.blk_ok = ({1'b0, i_req.block_in} < (fbpa_pkg::BLK_W + 1)'(fbpa_pkg::BLOCKS));
        unique case (i_req.func)
            1'b0:    cmd_in.op = fbpa_pkg::OP_ALLOC;
            default: cmd_in.op = fbpa_pkg::OP_FREE;
        endcase
    end

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

    assign o_cmd           = r_q[r_rd_ptr];
    assign o_stat.nonempty = (r_count != 2'd0);
    assign o_stat.multi    = (r_count == 2'd2);

endmodule

// File: hdl/fbpa_back.sv
// fbpa_back: carries out allocate and free commands on the free list,
// owns the link memory and the result register; depends on fbpa_pkg, fbpa_rsp_if

module fbpa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fbpa_pkg::t_cmd       i_cmd,
    input  fbpa_pkg::t_q_stat    i_stat,
    output logic                 o_pop,
    fbpa_rsp_if.source           o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [fbpa_pkg::CNT_W-1:0]   r_head, n_head;
    logic [fbpa_pkg::CNT_W-1:0]   r_free, n_free;
    logic [fbpa_pkg::CNT_W-1:0]   r_touched, n_touched;
    logic [fbpa_pkg::CNT_W-1:0]   r_rdata;
    logic [fbpa_pkg::CNT_W-1:0]   r_mem [fbpa_pkg::BLOCKS];

    logic               r_out_valid;
    logic               r_granted, n_granted;
    logic [fbpa_pkg::BLK_W-1:0]  r_block_out, n_block_out;
    logic [fbpa_pkg::FCNT_W-1:0] r_free_count;
    logic               r_error, n_error;

    logic                         commit;
    logic                         we;
    logic [fbpa_pkg::IDX_W-1:0]   waddr;
    logic [fbpa_pkg::CNT_W-1:0]   wdata;
    logic                         lazy;
    logic [fbpa_pkg::CNT_W-1:0]   pop_free;
    logic [fbpa_pkg::CNT_W-1:0]   link_val;

    assign commit = (r_state == S_COMMIT) && (!r_out_valid || o_rsp.ready);
    assign o_pop  = commit;
    assign lazy   = (r_touched < fbpa_pkg::BLOCKS_C);

    // link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_head[fbpa_pkg::IDX_W-1:0]];
        end
    end

    // successor of the head; the lazy link written this cycle is forwarded
    always_comb begin
        pop_free = r_free - fbpa_pkg::CNT_W'(1);
        if (r_head >= fbpa_pkg::BLOCKS_C) begin
            link_val = '0;
        end else if (lazy && (r_head == r_touched)) begin
            link_val = r_touched + fbpa_pkg::CNT_W'(1);
        end else begin
            link_val = r_rdata;
        end
    end

    // command execution
    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_touched   = r_touched;
        n_granted   = 1'b0;
        n_block_out = '0;
        n_error     = 1'b0;
        we          = 1'b0;
        waddr       = r_touched[fbpa_pkg::IDX_W-1:0];
        wdata       = r_touched + fbpa_pkg::CNT_W'(1);
        if (commit) begin
            unique case (i_cmd.op)
                fbpa_pkg::OP_ALLOC: begin
                    if (lazy) begin
                        we        = 1'b1;
                        n_touched = r_touched + fbpa_pkg::CNT_W'(1);
                    end
                    if (r_free != '0) begin
                        n_granted   = 1'b1;
                        n_block_out = r_head[fbpa_pkg::BLK_W-1:0];
                        n_free      = pop_free;
                        if (pop_free != '0) begin
                            n_head = link_val;
                        end
                    end
                end
                default: begin
                    if (r_free >= fbpa_pkg::BLOCKS_C) begin
                        n_error = 1'b1;
                    end else if (i_cmd.blk_ok) begin
                        we     = 1'b1;
                        waddr  = fbpa_pkg::IDX_W'(i_cmd.blk);
                        wdata  = (r_free != '0) ? r_head : fbpa_pkg::BLOCKS_C;
                        n_head = fbpa_pkg::CNT_W'(i_cmd.blk);
                        n_free = r_free + fbpa_pkg::CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_stat.nonempty) n_state = S_READ;
            S_READ:   n_state = S_COMMIT;
            S_COMMIT: if (commit) n_state = i_stat.multi ? S_READ : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free      <= fbpa_pkg::BLOCKS_C;
            r_touched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_touched <= n_touched;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_granted    <= n_granted;
            r_block_out  <= n_block_out;
            r_free_count <= fbpa_pkg::FCNT_W'(n_free);
            r_error      <= n_error;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.granted    = r_granted;
    assign o_rsp.block_out  = r_block_out;
    assign o_rsp.free_count = r_free_count;
    assign o_rsp.error      = r_error;

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// fixed_block_pool_allocator: index-based block pool with a lazily built free list
// each accepted request word is queued, then the back-end sequencer does a link memory read
// and then a commit into the result register, which waits while a result is not taken;
// a two-entry queue decouples the request side
// reset: synchronous, clears the queue, sequencer, head, counts; link memory is not cleared
// depends on fbpa_pkg, fbpa_if, fbpa_front, fbpa_back

module fixed_block_pool_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbpa_req_if.sink    i_req,
    fbpa_rsp_if.source  o_rsp
);

    fbpa_pkg::t_cmd    cmd;
    fbpa_pkg::t_q_stat stat;
    logic              pop;

    // request queue and classification
    fbpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_cmd   (cmd),
        .o_stat  (stat)
    );

    // free list execution
    fbpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
